/* rtl/ecs_pkg.sv */
package ecs_pkg;

  localparam int unsigned NumFloors = 32;
  localparam int unsigned FloorW    = 5;
  localparam int unsigned MapW      = 32;
  localparam int unsigned CarW      = 4;
  localparam int unsigned DirW      = 2;
  localparam int unsigned CfgW      = 8;
  localparam int unsigned CostW     = 20;

  // sum of target distances: at most MapW targets, each at most 31 floors away
  localparam int unsigned DsumW  = 10;
  // plus up to two extra legs of at most 31 floors each
  localparam int unsigned DistW  = 11;
  // targets + current-way stops + stops passed, at most 3 * MapW
  localparam int unsigned NStopW = 7;
  localparam int unsigned PaW    = DistW + CfgW;
  localparam int unsigned PbW    = NStopW + CfgW;

  localparam int unsigned ScanLen = (NumFloors > MapW) ? MapW : NumFloors;
  localparam int unsigned StepW   = (ScanLen > 1) ? $clog2(ScanLen) : 1;

  localparam logic [MapW-1:0] FloorMask = (NumFloors >= MapW) ? {MapW{1'b1}} :
      MapW'((64'(1) << NumFloors) - 64'(1));

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);

  localparam logic [DirW-1:0] DirNone = 2'd0;
  localparam logic [DirW-1:0] DirUp   = 2'd1;
  localparam logic [DirW-1:0] DirDown = 2'd2;

  localparam logic CfgFloorTravel = 1'b0;
  localparam logic CfgStop        = 1'b1;

  localparam logic [CfgW-1:0] CfgReset = 8'd1;
  localparam logic [CostW-1:0] CostMax = {CostW{1'b1}};

  typedef enum logic [1:0] {
    KindInfeasible = 2'd0,
    KindIdle       = 2'd1,
    KindSame       = 2'd2,
    KindReverse    = 2'd3
  } ecs_kind_e;

  typedef struct packed {
    logic [FloorW-1:0] pickup_floor;
    logic [DirW-1:0]   request_dir;
    logic [MapW-1:0]   target_floors;
    logic [CarW-1:0]   car_id;
    logic              car_idle;
    logic [FloorW-1:0] car_floor;
    logic [DirW-1:0]   car_dir;
    logic [MapW-1:0]   up_stops;
    logic [MapW-1:0]   down_stops;
    logic              last_candidate;
  } ecs_in_t;

  typedef struct packed {
    logic              found;
    logic [CarW-1:0]   chosen_car;
    logic [CostW-1:0]  chosen_cost;
  } ecs_out_t;

  typedef struct packed {
    ecs_kind_e         kind;
    logic              last;
    logic [CarW-1:0]   car_id;
    logic [FloorW-1:0] pickup;
    logic [FloorW-1:0] car_floor;
    logic [FloorW-1:0] lo;
    logic [FloorW-1:0] hi;
    logic              bet_en;
    logic              desc;
    logic              opp_en;
    logic [MapW-1:0]   targets;
    logic [MapW-1:0]   cur;
    logic [MapW-1:0]   opp;
  } ecs_task_t;

  function automatic logic [FloorW-1:0] floor_dist(input logic [FloorW-1:0] a,
                                                   input logic [FloorW-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

/* rtl/ecs_front.sv */
module ecs_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ecs_pkg::ecs_in_t  in_data_i,
  output logic              task_valid_o,
  input  logic              task_ready_i,
  output ecs_pkg::ecs_task_t task_o
);

  ecs_pkg::ecs_task_t cls;
  logic [ecs_pkg::MapW-1:0] targets, ups, downs;
  logic cdir_up;

  ecs_pkg::ecs_task_t q_mem [ecs_pkg::QueueDepth];
  logic [ecs_pkg::QPtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [ecs_pkg::QPtrW:0]   count_q, count_d;
  logic push, pop;

  always_comb begin
    targets = in_data_i.target_floors & ecs_pkg::FloorMask;
    ups     = in_data_i.up_stops & ecs_pkg::FloorMask;
    downs   = in_data_i.down_stops & ecs_pkg::FloorMask;
    cdir_up = (in_data_i.car_dir == ecs_pkg::DirUp);

    cls.kind      = ecs_pkg::KindInfeasible;
    cls.last      = in_data_i.last_candidate;
    cls.car_id    = in_data_i.car_id;
    cls.pickup    = in_data_i.pickup_floor;
    cls.car_floor = in_data_i.car_floor;
    cls.targets   = targets;
    cls.lo        = in_data_i.pickup_floor;
    cls.hi        = in_data_i.car_floor;
    cls.bet_en    = 1'b0;
    cls.desc      = 1'b0;
    cls.opp_en    = 1'b0;
    cls.cur       = downs;
    cls.opp       = ups;

    priority if (targets == '0) begin
      cls.kind = ecs_pkg::KindInfeasible;
    end else if (in_data_i.car_idle) begin
      cls.kind = ecs_pkg::KindIdle;
    end else if (in_data_i.car_dir == in_data_i.request_dir ||
                 in_data_i.request_dir == ecs_pkg::DirNone) begin
      if ((in_data_i.request_dir == ecs_pkg::DirUp &&
           in_data_i.car_floor > in_data_i.pickup_floor) ||
          (in_data_i.request_dir == ecs_pkg::DirDown &&
           in_data_i.car_floor < in_data_i.pickup_floor)) begin
        cls.kind = ecs_pkg::KindInfeasible;
      end else begin
        cls.kind   = ecs_pkg::KindSame;
        cls.bet_en = (in_data_i.request_dir == ecs_pkg::DirUp) ||
                     (in_data_i.request_dir == ecs_pkg::DirDown);
        if (in_data_i.request_dir == ecs_pkg::DirUp) begin
          cls.cur = ups;
          cls.lo  = in_data_i.car_floor;
          cls.hi  = in_data_i.pickup_floor;
        end
      end
    end else begin
      cls.kind   = ecs_pkg::KindReverse;
      cls.desc   = cdir_up;
      cls.opp_en = cdir_up || (in_data_i.car_dir == ecs_pkg::DirDown);
      cls.cur    = cdir_up ? ups : downs;
      cls.opp    = cdir_up ? downs : ups;
    end
  end

  assign in_ready_o   = (count_q != (ecs_pkg::QPtrW+1)'(ecs_pkg::QueueDepth));
  assign task_valid_o = (count_q != '0);
  assign task_o       = q_mem[rd_ptr_q];
  assign push         = in_valid_i && in_ready_o;
  assign pop          = task_valid_o && task_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + (ecs_pkg::QPtrW+1)'(push) - (ecs_pkg::QPtrW+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= cls;
    end
  end

endmodule

/* rtl/ecs_back.sv */
module ecs_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      task_valid_i,
  output logic                      task_ready_o,
  input  ecs_pkg::ecs_task_t        task_i,
  input  logic [ecs_pkg::CfgW-1:0]  floor_travel_cost_i,
  input  logic [ecs_pkg::CfgW-1:0]  stop_cost_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output ecs_pkg::ecs_out_t         out_data_o
);

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StScan = 5'b00010,
    StDist = 5'b00100,
    StMul  = 5'b01000,
    StAcc  = 5'b10000
  } ecs_state_e;

  ecs_state_e state_q, state_d;
  ecs_pkg::ecs_task_t tsk_q, tsk_d;
  logic [ecs_pkg::StepW-1:0]  step_q, step_d;
  logic                       found_q, found_d;
  logic [ecs_pkg::FloorW-1:0] far_q, far_d;
  logic [ecs_pkg::DsumW-1:0]  dsum_q, dsum_d;
  logic [ecs_pkg::NStopW-1:0] nstop_q, nstop_d;
  logic [ecs_pkg::DistW-1:0]  dist_q, dist_d;
  logic [ecs_pkg::PaW-1:0]    pa_q, pa_d;
  logic [ecs_pkg::PbW-1:0]    pb_q, pb_d;
  logic [ecs_pkg::CostW-1:0]  best_cost_q, best_cost_d;
  logic [ecs_pkg::CarW-1:0]   best_car_q, best_car_d;
  logic                       have_best_q, have_best_d;
  logic                       out_valid_q, out_valid_d;
  ecs_pkg::ecs_out_t          out_q, out_d;

  logic [ecs_pkg::FloorW-1:0] idx;
  logic                       tb, same_bit, rev_cur_bit, rev_opp_bit, beyond;
  logic [ecs_pkg::FloorW:0]   extra;
  logic [ecs_pkg::CostW-1:0]  cost;
  logic                       better, out_free;
  logic [ecs_pkg::CostW-1:0]  nb_cost;
  logic [ecs_pkg::CarW-1:0]   nb_car;
  logic                       nb_have;

  assign task_ready_o = (state_q == StIdle);
  assign out_valid_o  = out_valid_q;
  assign out_data_o   = out_q;
  assign out_free     = !out_valid_q || out_ready_i;

  always_comb begin
    idx = tsk_q.desc ?
          ecs_pkg::FloorW'(ecs_pkg::ScanLen - 1) - ecs_pkg::FloorW'(step_q) :
          ecs_pkg::FloorW'(step_q);
    tb       = tsk_q.targets[idx];
    same_bit = (tsk_q.kind == ecs_pkg::KindSame) && tsk_q.bet_en && tsk_q.cur[idx] &&
               (idx > tsk_q.lo) && (idx < tsk_q.hi);
    rev_cur_bit = (tsk_q.kind == ecs_pkg::KindReverse) && tsk_q.cur[idx];
    beyond = tsk_q.desc ? ((idx < far_q) && (idx > tsk_q.pickup)) :
                          ((idx > far_q) && (idx < tsk_q.pickup));
    rev_opp_bit = (tsk_q.kind == ecs_pkg::KindReverse) && tsk_q.opp_en && found_q &&
                  tsk_q.opp[idx] && beyond;

    if (tsk_q.kind == ecs_pkg::KindReverse) begin
      extra = {1'b0, ecs_pkg::floor_dist(tsk_q.car_floor, far_q)} +
              {1'b0, ecs_pkg::floor_dist(far_q, tsk_q.pickup)};
    end else begin
      extra = {1'b0, ecs_pkg::floor_dist(tsk_q.car_floor, tsk_q.pickup)};
    end

    cost   = ecs_pkg::CostW'(pa_q) + ecs_pkg::CostW'(pb_q);
    better = (tsk_q.kind != ecs_pkg::KindInfeasible) && (!have_best_q || cost < best_cost_q);
    nb_cost = better ? cost : best_cost_q;
    nb_car  = better ? tsk_q.car_id : best_car_q;
    nb_have = better || have_best_q;
  end

  always_comb begin
    state_d     = state_q;
    tsk_d       = tsk_q;
    step_d      = step_q;
    found_d     = found_q;
    far_d       = far_q;
    dsum_d      = dsum_q;
    nstop_d     = nstop_q;
    dist_d      = dist_q;
    pa_d        = pa_q;
    pb_d        = pb_q;
    best_cost_d = best_cost_q;
    best_car_d  = best_car_q;
    have_best_d = have_best_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;

    unique case (state_q)
      StIdle: begin
        if (task_valid_i) begin
          tsk_d   = task_i;
          step_d  = '0;
          found_d = (task_i.cur == '0);
          far_d   = task_i.car_floor;
          dsum_d  = '0;
          nstop_d = '0;
          state_d = (task_i.kind == ecs_pkg::KindInfeasible) ? StAcc : StScan;
        end
      end
      StScan: begin
        if (tb) begin
          dsum_d = dsum_q + ecs_pkg::DsumW'(ecs_pkg::floor_dist(tsk_q.pickup, idx));
        end
        nstop_d = nstop_q + ecs_pkg::NStopW'(tb) + ecs_pkg::NStopW'(same_bit) +
                  ecs_pkg::NStopW'(rev_cur_bit) + ecs_pkg::NStopW'(rev_opp_bit);
        if (!found_q && tsk_q.cur[idx]) begin
          found_d = 1'b1;
          far_d   = idx;
        end
        step_d = step_q + 1'b1;
        if (step_q == ecs_pkg::StepW'(ecs_pkg::ScanLen - 1)) begin
          state_d = StDist;
        end
      end
      StDist: begin
        dist_d  = ecs_pkg::DistW'(dsum_q) + ecs_pkg::DistW'(extra);
        state_d = StMul;
      end
      StMul: begin
        pa_d    = ecs_pkg::PaW'(dist_q) * ecs_pkg::PaW'(floor_travel_cost_i);
        pb_d    = ecs_pkg::PbW'(nstop_q) * ecs_pkg::PbW'(stop_cost_i);
        state_d = StAcc;
      end
      StAcc: begin
        if (!tsk_q.last) begin
          best_cost_d = nb_cost;
          best_car_d  = nb_car;
          have_best_d = nb_have;
          state_d     = StIdle;
        end else if (out_free) begin
          out_d.found       = nb_have;
          out_d.chosen_car  = nb_have ? nb_car : '0;
          out_d.chosen_cost = nb_have ? nb_cost : '0;
          out_valid_d       = 1'b1;
          best_cost_d       = ecs_pkg::CostMax;
          best_car_d        = '0;
          have_best_d       = 1'b0;
          state_d           = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      step_q      <= '0;
      found_q     <= 1'b0;
      best_cost_q <= ecs_pkg::CostMax;
      best_car_q  <= '0;
      have_best_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      found_q     <= found_d;
      best_cost_q <= best_cost_d;
      best_car_q  <= best_car_d;
      have_best_q <= have_best_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tsk_q   <= tsk_d;
    far_q   <= far_d;
    dsum_q  <= dsum_d;
    nstop_q <= nstop_d;
    dist_q  <= dist_d;
    pa_q    <= pa_d;
    pb_q    <= pb_d;
    out_q   <= out_d;
  end

endmodule

/* rtl/elevator_dispatch_cost_select.sv */
// Channel   Handshake                   Payload
// in        in_valid_i / in_ready_o     in_data_i  (one candidate car)
// out       out_valid_o / out_ready_i   out_data_o (best car, on last candidate)
// cfg       cfg_we_i                    cfg_idx_i, cfg_data_i
//
// A feasible candidate passes the back end in order: load, a scan of each
// floor in the bitmaps, then distance, multiply and compare steps. An
// infeasible one goes from load straight to compare. A 2-beat queue keeps the
// input open while the back end scans; a full output register stalls only a
// last candidate. Reset sets both cost weights to 1 and clears the running best.
module elevator_dispatch_cost_select (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  ecs_pkg::ecs_in_t          in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output ecs_pkg::ecs_out_t         out_data_o,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [ecs_pkg::CfgW-1:0]  cfg_data_i
);

  logic [ecs_pkg::CfgW-1:0] ftc_q, ftc_d, sc_q, sc_d;
  logic               task_valid, task_ready;
  ecs_pkg::ecs_task_t task_data;

  always_comb begin
    ftc_d = ftc_q;
    sc_d  = sc_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ecs_pkg::CfgFloorTravel: ftc_d = cfg_data_i;
        ecs_pkg::CfgStop:        sc_d  = cfg_data_i;
        default: begin
          ftc_d = ftc_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ftc_q <= ecs_pkg::CfgReset;
      sc_q  <= ecs_pkg::CfgReset;
    end else begin
      ftc_q <= ftc_d;
      sc_q  <= sc_d;
    end
  end

  ecs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .task_valid_o (task_valid),
    .task_ready_i (task_ready),
    .task_o       (task_data)
  );

  ecs_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .task_valid_i        (task_valid),
    .task_ready_o        (task_ready),
    .task_i              (task_data),
    .floor_travel_cost_i (ftc_q),
    .stop_cost_i         (sc_q),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .out_data_o          (out_data_o)
  );

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import ecs_pkg::*;

  localparam logic [DirW-1:0] DirOther = 2'd3;
  localparam int unsigned CycleLimit   = 600000;
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned TailCycles   = 80;
  localparam int unsigned IdlePct      = 29;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  ecs_in_t          in_data_i;
  logic             out_valid_o;
  logic             out_ready_i;
  ecs_out_t         out_data_o;
  logic             cfg_we_i;
  logic             cfg_idx_i;
  logic [CfgW-1:0]  cfg_data_i;

  // dispatcher model state
  int unsigned      floor_weight;
  int unsigned      stop_weight;
  int unsigned      cheapest_cost;
  logic [CarW-1:0]  cheapest_car;
  bit               have_cheapest;
  ecs_out_t         expected_picks[$];

  int unsigned      mismatches;
  int unsigned      cycles;
  int unsigned      hold_req;
  int unsigned      hold_left;
  bit               no_gaps;

  elevator_dispatch_cost_select dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic int unsigned span(input int unsigned a, input int unsigned b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic int unsigned stops_between(input logic [MapW-1:0] m,
                                                input int unsigned lo, input int unsigned hi);
    int unsigned n;
    n = 0;
    for (int i = 0; i < MapW; i++) begin
      if (m[i] && i > lo && i < hi) n++;
    end
    return n;
  endfunction

  function automatic bit candidate_cost(input ecs_in_t c, output int unsigned cost);
    int unsigned total;
    int unsigned pk;
    int unsigned cf;
    int unsigned far;
    logic [MapW-1:0] cur;
    logic [MapW-1:0] opp;
    total = 0;
    cost  = 0;
    pk    = 32'(c.pickup_floor);
    cf    = 32'(c.car_floor);
    if (c.target_floors == '0) return 1'b0;
    for (int i = 0; i < MapW; i++) begin
      if (c.target_floors[i]) total += span(pk, i) * floor_weight;
    end
    total += $countones(c.target_floors) * stop_weight;
    if (c.car_idle) begin
      total += span(cf, pk) * floor_weight;
    end else if (c.car_dir == c.request_dir || c.request_dir == DirNone) begin
      if ((c.request_dir == DirUp && cf > pk) || (c.request_dir == DirDown && cf < pk))
        return 1'b0;
      total += span(cf, pk) * floor_weight;
      if (c.request_dir == DirUp) begin
        total += stops_between(c.up_stops, cf, pk) * stop_weight;
      end else if (c.request_dir == DirDown) begin
        total += stops_between(c.down_stops, pk, cf) * stop_weight;
      end
    end else begin
      cur = (c.car_dir == DirUp) ? c.up_stops : c.down_stops;
      opp = (c.car_dir == DirUp) ? c.down_stops : c.up_stops;
      far = cf;
      if (c.car_dir == DirUp) begin
        for (int i = 0; i < MapW; i++) begin
          if (cur[i]) far = i;
        end
      end else begin
        for (int i = MapW - 1; i >= 0; i--) begin
          if (cur[i]) far = i;
        end
      end
      total += span(cf, far) * floor_weight;
      total += $countones(cur) * stop_weight;
      total += span(far, pk) * floor_weight;
      if (c.car_dir == DirUp) begin
        total += stops_between(opp, pk, far) * stop_weight;
      end else if (c.car_dir == DirDown) begin
        total += stops_between(opp, far, pk) * stop_weight;
      end
    end
    cost = (total > 32'(CostMax)) ? 32'(CostMax) : total;
    return 1'b1;
  endfunction

  function automatic void track_cheapest(input ecs_in_t c);
    int unsigned cost;
    bit          feasible;
    ecs_out_t    pick;
    feasible = candidate_cost(c, cost);
    if (feasible && (!have_cheapest || cost < cheapest_cost)) begin
      cheapest_cost = cost;
      cheapest_car  = c.car_id;
      have_cheapest = 1'b1;
    end
    if (c.last_candidate) begin
      pick.found       = have_cheapest;
      pick.chosen_car  = have_cheapest ? cheapest_car : '0;
      pick.chosen_cost = have_cheapest ? CostW'(cheapest_cost) : '0;
      expected_picks.push_back(pick);
      cheapest_cost = 32'(CostMax);
      cheapest_car  = '0;
      have_cheapest = 1'b0;
    end
  endfunction

  // result check first, then prediction of the beat accepted at this edge
  always @(posedge clk_i) begin : scoreboard
    ecs_out_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_picks.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: found %0d car %0d cost %0d",
                     out_data_o.found, out_data_o.chosen_car, out_data_o.chosen_cost);
        end else begin
          want = expected_picks.pop_front();
          if (out_data_o.found !== want.found || out_data_o.chosen_car !== want.chosen_car ||
              out_data_o.chosen_cost !== want.chosen_cost) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: found exp %0d got %0d, car exp %0d got %0d, cost exp %0d got %0d",
                       want.found, out_data_o.found, want.chosen_car, out_data_o.chosen_car,
                       want.chosen_cost, out_data_o.chosen_cost);
          end
        end
      end
      if (in_valid_i && in_ready_o) track_cheapest(in_data_i);
    end
  end

  // result side: random stalls, plus long hold-offs on request
  always @(posedge clk_i) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left--;
    end else begin
      out_ready_i <= no_gaps || ($urandom_range(99) >= IdlePct);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_candidate(input ecs_in_t c);
    if (!no_gaps) begin
      while ($urandom_range(99) < IdlePct) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    in_data_i  <= c;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_picks.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_weights(input logic [CfgW-1:0] travel, input logic [CfgW-1:0] per_stop);
    wait_drained();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CfgFloorTravel;
    cfg_data_i <= travel;
    @(posedge clk_i);
    cfg_idx_i  <= CfgStop;
    cfg_data_i <= per_stop;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    floor_weight = 32'(travel);
    stop_weight  = 32'(per_stop);
  endtask

  function automatic ecs_in_t car_offer(
    input logic [FloorW-1:0] pickup, input logic [DirW-1:0] rdir,
    input logic [MapW-1:0] targets, input logic [CarW-1:0] id, input logic idle,
    input logic [FloorW-1:0] car_at, input logic [DirW-1:0] cdir,
    input logic [MapW-1:0] ups, input logic [MapW-1:0] downs, input logic last);
    ecs_in_t c;
    c.pickup_floor   = pickup;
    c.request_dir    = rdir;
    c.target_floors  = targets;
    c.car_id         = id;
    c.car_idle       = idle;
    c.car_floor      = car_at;
    c.car_dir        = cdir;
    c.up_stops       = ups;
    c.down_stops     = downs;
    c.last_candidate = last;
    return c;
  endfunction

  function automatic logic [DirW-1:0] random_dir();
    int unsigned r;
    r = $urandom_range(19);
    if (r == 0) return DirOther;
    if (r < 7) return DirNone;
    if (r < 14) return DirUp;
    return DirDown;
  endfunction

  function automatic logic [MapW-1:0] random_map();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2, 3, 4: return (MapW'(1) << $urandom_range(MapW - 1)) |
                      (MapW'(1) << $urandom_range(MapW - 1));
      default: return MapW'($urandom);
    endcase
  endfunction

  task automatic send_random_request(input int unsigned n_cars);
    ecs_in_t c;
    ecs_in_t prev;
    c.pickup_floor  = FloorW'($urandom_range(31));
    c.request_dir   = random_dir();
    c.target_floors = random_map();
    prev = c;
    for (int k = 0; k < n_cars; k++) begin
      if (k > 0 && $urandom_range(7) == 0) begin
        // same car state under another id: tie on cost
        c = prev;
        c.car_id = CarW'($urandom_range(15));
      end else begin
        c.car_id     = CarW'($urandom_range(15));
        c.car_idle   = ($urandom_range(3) == 0);
        c.car_floor  = FloorW'($urandom_range(31));
        c.car_dir    = ($urandom_range(9) < 4) ? c.request_dir : random_dir();
        c.up_stops   = random_map();
        c.down_stops = random_map();
      end
      if ($urandom_range(19) == 0) begin
        // request fields changing inside one request
        c.pickup_floor  = FloorW'($urandom_range(31));
        c.request_dir   = random_dir();
        c.target_floors = random_map();
      end
      c.last_candidate = (k == n_cars - 1);
      prev = c;
      send_candidate(c);
    end
  endtask

  function automatic int unsigned random_fleet();
    return ($urandom_range(7) == 0) ? $urandom_range(5, 16) : $urandom_range(1, 4);
  endfunction

  task automatic test_directed();
    // no targets
    send_candidate(car_offer(5, DirUp, '0, 3, 0, 2, DirUp, '0, '0, 1));
    // idle cars at the building's ends
    send_candidate(car_offer(0, DirNone, 32'h8000_0000, 15, 1, 31, DirNone, '1, '1, 1));
    send_candidate(car_offer(31, DirDown, 32'h0000_0001, 0, 1, 0, DirDown, '0, '0, 1));
    // up request: same way with stops passed, car above, idle, reversal from down
    send_candidate(car_offer(20, DirUp, 32'h0100_0000, 1, 0, 4, DirUp,
                             32'h000F_0F30, 32'h0000_0040, 0));
    send_candidate(car_offer(20, DirUp, 32'h0100_0000, 2, 0, 25, DirUp, '0, '0, 0));
    send_candidate(car_offer(20, DirUp, 32'h0100_0000, 3, 1, 20, DirUp, '0, '0, 0));
    send_candidate(car_offer(20, DirUp, 32'h0100_0000, 4, 0, 10, DirDown,
                             32'h0000_8000, 32'h0000_0104, 1));
    // down request
    send_candidate(car_offer(12, DirDown, 32'h0000_0011, 5, 0, 28, DirDown,
                             '0, 32'h0004_2000, 0));
    send_candidate(car_offer(12, DirDown, 32'h0000_0011, 6, 0, 3, DirDown, '0, '0, 0));
    send_candidate(car_offer(12, DirDown, 32'h0000_0011, 7, 0, 9, DirUp,
                             32'h4000_0400, 32'h0010_0000, 0));
    send_candidate(car_offer(12, DirDown, 32'h0000_0011, 8, 0, 12, DirNone, '0, '0, 0));
    send_candidate(car_offer(12, DirDown, 32'h0000_0011, 9, 1, 0, DirNone, '0, '0, 1));
    // no direction requested
    send_candidate(car_offer(7, DirNone, 32'hFFFF_0000, 10, 0, 3, DirUp,
                             32'h0000_0020, 32'h0000_0010, 0));
    send_candidate(car_offer(7, DirNone, 32'hFFFF_0000, 11, 0, 30, DirDown, '0, '1, 0));
    send_candidate(car_offer(7, DirNone, 32'hFFFF_0000, 12, 0, 7, DirOther, '0, '1, 1));
    // direction code three
    send_candidate(car_offer(16, DirOther, 32'h0000_0001, 13, 0, 2, DirOther,
                             '1, 32'h0000_0100, 0));
    send_candidate(car_offer(16, DirOther, 32'h0000_0001, 14, 0, 5, DirUp,
                             32'h0000_0C00, 32'h0000_3000, 0));
    send_candidate(car_offer(16, DirOther, 32'h0000_0001, 0, 0, 31, DirNone, '0, '0, 1));
    send_candidate(car_offer(9, DirUp, 32'h0000_0400, 6, 0, 20, DirOther,
                             32'h0000_0080, 32'h0001_1000, 1));
    // tie: first of equal costs wins
    send_candidate(car_offer(3, DirUp, 32'h0000_0100, 7, 0, 1, DirUp, 32'h4, '0, 0));
    send_candidate(car_offer(3, DirUp, 32'h0000_0100, 9, 0, 1, DirUp, 32'h4, '0, 0));
    send_candidate(car_offer(3, DirUp, 32'h0000_0100, 2, 0, 0, DirUp, '1, '0, 1));
    // every bitmap full
    send_candidate(car_offer(0, DirDown, '1, 15, 0, 31, DirUp, '1, '1, 1));
  endtask

  task automatic test_weight_extremes();
    logic [CfgW-1:0] travel [4];
    logic [CfgW-1:0] per_stop [4];
    travel   = '{8'd0, 8'd255, 8'd0, 8'd255};
    per_stop = '{8'd0, 8'd255, 8'd255, 8'd0};
    for (int s = 0; s < 4; s++) begin
      set_weights(travel[s], per_stop[s]);
      send_candidate(car_offer(0, DirDown, '1, 15, 0, 0, DirUp, '1, '1, 1));
      repeat (15) send_random_request(random_fleet());
    end
  endtask

  task automatic test_random();
    for (int p = 0; p < 10; p++) begin
      set_weights(($urandom_range(5) == 0) ? 8'd1 : 8'($urandom),
                  ($urandom_range(5) == 0) ? 8'd1 : 8'($urandom));
      repeat (32) send_random_request(random_fleet());
    end
  endtask

  task automatic test_no_idle();
    wait_drained();
    no_gaps = 1'b1;
    repeat (60) send_random_request(random_fleet());
    wait_drained();
    no_gaps = 1'b0;
  endtask

  task automatic test_backpressure();
    hold_req = 800;
    repeat (24) send_random_request(1);
    wait_drained();
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    <= 1'b0;
    in_data_i     <= '0;
    out_ready_i   <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CfgFloorTravel;
    cfg_data_i    <= '0;
    floor_weight  = 1;
    stop_weight   = 1;
    cheapest_cost = 32'(CostMax);
    cheapest_car  = '0;
    have_cheapest = 1'b0;
    mismatches    = 0;
    cycles        = 0;
    hold_req      = 0;
    hold_left     = 0;
    no_gaps       = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_weight_extremes();
    test_backpressure();
    test_random();
    test_no_idle();

    wait_drained();
    repeat (TailCycles) @(posedge clk_i);
    if (mismatches == 0 && expected_picks.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
